[hdl/bpja_pkg.sv]
package bpja_pkg;

	// Default sizes and bin widths
	localparam int NUM_BINS_DEF     = 256;
	localparam int NUM_BLOCKS_DEF   = 16;
	localparam int FINE_WIDTH_DEF   = 1000;
	localparam int COARSE_WIDTH_DEF = 5000;

	// Field widths
	localparam int EDGE_W  = 22;
	localparam int VALUE_W = 24;
	localparam int PHENO_W = 16;
	localparam int BLOCK_W = 4;
	localparam int BINF_W  = 8;
	localparam int COUNT_W = 40;
	localparam int SUM_W   = 64;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 176;

	// Divider sizes: dividends are edge differences, divisors bin widths
	localparam int DIVD_W = 25;
	localparam int DIVS_W = 17;
	localparam int LOC_W  = DIVD_W + 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_BLOCK_COUNT = 3'd0,
		REG_LOW_EDGE    = 3'd1,
		REG_FINE_START  = 3'd2,
		REG_FINE_END    = 3'd3,
		REG_HIGH_EDGE   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_ACCUM     = 2'd0,
		OP_READ_FULL = 2'd1,
		OP_READ_LOO  = 2'd2,
		OP_SPARE     = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		STAT_USED    = 3'd0,
		STAT_DIAG    = 3'd1,
		STAT_MISSING = 3'd2,
		STAT_RANGE   = 3'd3,
		STAT_READ    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CHECK, ST_DIV_START, ST_DIV_WAIT, ST_BIN,
		ST_RD_A, ST_WR_A, ST_RD_B, ST_WR_B, ST_RD_Q, ST_OUT
	} state_t;

	// One table entry
	typedef struct packed {
		logic signed [SUM_W-1:0] psum;
		logic signed [SUM_W-1:0] vsum;
		logic [COUNT_W-1:0]      count;
	} acc_t;

	localparam int ACC_W = $bits(acc_t);

	function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b);
		logic signed [SUM_W-1:0] s;
		s = a + b;
		if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1])
			s = a[SUM_W-1] ? SUM_MIN : SUM_MAX;
		return s;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sub(input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b);
		logic signed [SUM_W-1:0] s;
		s = a - b;
		if (a[SUM_W-1] != b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1])
			s = a[SUM_W-1] ? SUM_MIN : SUM_MAX;
		return s;
	endfunction

	function automatic acc_t acc_add(input acc_t e, input logic signed [SUM_W-1:0] v,
		input logic signed [SUM_W-1:0] p);
		acc_t r;
		r.count = (e.count == COUNT_MAX) ? e.count : e.count + COUNT_W'(1);
		r.vsum  = sat_add(e.vsum, v);
		r.psum  = sat_add(e.psum, p);
		return r;
	endfunction

endpackage

[hdl/binned_pair_jackknife_accumulator.sv]
// Binned pair accumulator with jackknife blocks. Each input word is either a
// pair to accumulate (s_tuser = 0) or a read of a bin's full totals (1 or 3)
// or its leave-one-out totals for one block (2); every word gives exactly one
// result word. Items are handled one at a time. After reset the block clears
// both tables, one entry per cycle, through all NUM_BLOCKS*NUM_BINS entries of
// the block table (4096 at the defaults), and holds s_tready low meanwhile;
// configuration writes are taken at any time. A read passes through the check,
// table-read and output steps. A binned pair is located by four divisions by
// the bin widths through one shared reciprocal-multiply divider, then takes
// one or two read-modify-write passes over the table memories, two when its
// clamped blocks differ. Skipped pairs go from the check straight to the output
// step, and pairs beyond the last bin skip the table passes. s_tready rises the
// cycle after the result is loaded; a result word held by m_tready low stalls
// the output step and with it the input.
module binned_pair_jackknife_accumulator
	import bpja_pkg::*;
#(
	parameter int NUM_BINS     = NUM_BINS_DEF,
	parameter int NUM_BLOCKS   = NUM_BLOCKS_DEF,
	parameter int FINE_WIDTH   = FINE_WIDTH_DEF,
	parameter int COARSE_WIDTH = COARSE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [EDGE_W-1:0]     cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// pair_value, pheno_first, pheno_second, block_first, block_second,
	// keep_first, keep_second, on_diagonal, read_bin, read_block, pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// bin_index, pair_count, value_sum, product_sum
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [2:0]            m_tuser
);

	localparam int BIN_AW     = $clog2(NUM_BINS);
	localparam int DROP_DEPTH = NUM_BLOCKS * NUM_BINS;
	localparam int DROP_AW    = $clog2(DROP_DEPTH);

	state_t state_q, state_d;

	// configuration
	logic [4:0]               bc_q;
	logic signed [EDGE_W-1:0] le_q, fs_q, fe_q, he_q;

	// current item
	opcode_t                   op_q;
	logic signed [VALUE_W-1:0] x_q;
	logic signed [PHENO_W-1:0] pa_q, pb_q;
	logic [BLOCK_W-1:0]        ba_q, bb_q, rblk_q;
	logic                      kf_q, ks_q, dg_q;
	logic [BINF_W-1:0]         rb_q;
	logic signed [SUM_W-1:0]   prod_q;

	// bin location
	logic [1:0]        sel_q;
	logic [DIVD_W-1:0] nf_q, nc_q, k_q, m_q;
	logic [DIVS_W-1:0] remf_q, remc_q;
	logic [LOC_W-1:0]  bin_q;
	status_t           status_q;
	logic [BINF_W-1:0] bin8_q;

	logic [DROP_AW-1:0] clr_q;

	// output register
	logic                    m_valid_q;
	status_t                 m_status_q;
	logic [BINF_W-1:0]       m_bin_q;
	logic [COUNT_W-1:0]      m_cnt_q;
	logic signed [SUM_W-1:0] m_vs_q, m_ps_q;

	// divider
	logic              div_start, div_done, div_coarse;
	logic [DIVD_W-1:0] div_dividend, div_quo;
	logic [DIVS_W-1:0] div_rem;

	// memories
	logic               full_we, full_re, drop_we, drop_re;
	logic [BIN_AW-1:0]  full_waddr, full_raddr;
	logic [DROP_AW-1:0] drop_waddr, drop_raddr;
	acc_t               full_wdata, drop_wdata, full_rdata, drop_rdata;

	// derived values
	logic [4:0]               nb;
	logic [BLOCK_W-1:0]       ba_eff, bb_eff;
	logic [BIN_AW-1:0]        bin_addr, rb_addr, acc_addr;
	logic [DROP_AW-1:0]       ia_addr, ib_addr, rq_addr;
	logic signed [25:0]       d_nf, d_nc, d_k, d_m;
	logic                     extra, ext_fine, rb_ok, loo, out_of_edges, skip_missing;
	logic [LOC_W-1:0]         nbins, bin_calc;
	logic [DIVD_W-1:0]        m_cl;
	logic signed [31:0]       prod_raw;
	logic signed [SUM_W-1:0]  x64;
	logic                     out_load;
	status_t                  res_status;
	logic [BINF_W-1:0]        res_bin;
	logic [COUNT_W-1:0]       res_cnt;
	logic signed [SUM_W-1:0]  res_vs, res_ps;

	// blocks in use, pair blocks clamped to the last one in use
	always_comb begin
		if (bc_q < 5'd2)
			nb = 5'd2;
		else if (32'(bc_q) > NUM_BLOCKS)
			nb = 5'(NUM_BLOCKS);
		else
			nb = bc_q;
		ba_eff = (5'(ba_q) >= nb) ? 4'(nb - 5'd1) : ba_q;
		bb_eff = (5'(bb_q) >= nb) ? 4'(nb - 5'd1) : bb_q;
	end

	assign bin_addr = BIN_AW'(bin_q);
	assign rb_addr  = BIN_AW'(rb_q);
	assign acc_addr = (op_q == OP_ACCUM) ? bin_addr : rb_addr;
	assign ia_addr  = DROP_AW'(DROP_AW'(ba_eff) * DROP_AW'(NUM_BINS) + DROP_AW'(bin_addr));
	assign ib_addr  = DROP_AW'(DROP_AW'(bb_eff) * DROP_AW'(NUM_BINS) + DROP_AW'(bin_addr));
	assign rq_addr  = DROP_AW'(DROP_AW'(rblk_q) * DROP_AW'(NUM_BINS) + DROP_AW'(rb_addr));
	assign rb_ok    = 32'(rb_q) < NUM_BINS;
	assign loo      = (op_q == OP_READ_LOO) && (5'(rblk_q) < nb);

	assign out_of_edges = (x_q < le_q) || (x_q > he_q);
	assign skip_missing = !kf_q || !ks_q;
	assign prod_raw     = pa_q * pb_q;
	assign x64          = SUM_W'(x_q);

	// divider operands: fine count, coarse count, fine offset, coarse offset
	assign d_nf = 26'(fe_q) - 26'(fs_q);
	assign d_nc = 26'(he_q) - 26'(fe_q);
	assign d_k  = 26'(x_q) - 26'(fs_q);
	assign d_m  = 26'(x_q) - 26'(fe_q);

	// odd steps divide by the coarse width
	assign div_coarse = sel_q[0];

	always_comb begin
		case (sel_q)
			2'd0: div_dividend = (fe_q >= fs_q) ? DIVD_W'(d_nf) : '0;
			2'd1: div_dividend = (he_q >= fe_q) ? DIVD_W'(d_nc) : '0;
			2'd2: div_dividend = (x_q >= fs_q) ? DIVD_W'(d_k) : '0;
			default: div_dividend = (x_q >= fe_q) ? DIVD_W'(d_m) : '0;
		endcase
	end

	bpja_div #(
		.FINE_WIDTH   (FINE_WIDTH),
		.COARSE_WIDTH (COARSE_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.coarse    (div_coarse),
		.dividend  (div_dividend),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// bin from the division results; the last edge is found from remainders
	always_comb begin
		ext_fine = (fe_q >= fs_q) ? ((26'(fe_q) - 26'(remf_q)) != 26'(he_q))
		                          : (fs_q != he_q);
		extra = (nc_q != '0) ? (remc_q != '0) : ext_fine;
		nbins = LOC_W'(1) + LOC_W'(nf_q) + LOC_W'(nc_q) + LOC_W'(extra);
		m_cl  = (m_q > nc_q) ? nc_q : m_q;
		if (x_q == he_q)
			bin_calc = nbins - LOC_W'(1);
		else if (x_q < fs_q)
			bin_calc = '0;
		else if (k_q < nf_q)
			bin_calc = LOC_W'(k_q) + LOC_W'(1);
		else
			bin_calc = LOC_W'(1) + LOC_W'(nf_q) + LOC_W'(m_cl);
	end

	bpja_ram #(.WIDTH(ACC_W), .DEPTH(NUM_BINS)) u_full (
		.clk   (clk),
		.we    (full_we),
		.waddr (full_waddr),
		.wdata (full_wdata),
		.re    (full_re),
		.raddr (full_raddr),
		.rdata (full_rdata)
	);

	bpja_ram #(.WIDTH(ACC_W), .DEPTH(DROP_DEPTH)) u_drop (
		.clk   (clk),
		.we    (drop_we),
		.waddr (drop_waddr),
		.wdata (drop_wdata),
		.re    (drop_re),
		.raddr (drop_raddr),
		.rdata (drop_rdata)
	);

	// result word
	always_comb begin
		res_status = status_q;
		res_bin    = bin8_q;
		res_cnt    = '0;
		res_vs     = '0;
		res_ps     = '0;
		if (op_q != OP_ACCUM) begin
			res_status = STAT_READ;
			res_bin    = rb_q;
			if (rb_ok) begin
				if (loo) begin
					res_cnt = (drop_rdata.count > full_rdata.count) ? '0
					        : full_rdata.count - drop_rdata.count;
					res_vs  = sat_sub(full_rdata.vsum, drop_rdata.vsum);
					res_ps  = sat_sub(full_rdata.psum, drop_rdata.psum);
				end else begin
					res_cnt = full_rdata.count;
					res_vs  = full_rdata.vsum;
					res_ps  = full_rdata.psum;
				end
			end
		end
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		full_we    = 1'b0;
		full_re    = 1'b0;
		drop_we    = 1'b0;
		drop_re    = 1'b0;
		full_waddr = acc_addr;
		full_raddr = acc_addr;
		drop_waddr = ia_addr;
		drop_raddr = ia_addr;
		full_wdata = acc_add(full_rdata, x64, prod_q);
		drop_wdata = acc_add(drop_rdata, x64, prod_q);
		out_load   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				full_we    = 32'(clr_q) < NUM_BINS;
				full_waddr = BIN_AW'(clr_q);
				full_wdata = '0;
				drop_we    = 1'b1;
				drop_waddr = clr_q;
				drop_wdata = '0;
				if (clr_q == DROP_AW'(DROP_DEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (op_q != OP_ACCUM)
					state_d = ST_RD_Q;
				else if (dg_q || skip_missing || out_of_edges)
					state_d = ST_OUT;
				else
					state_d = ST_DIV_START;
			end
			ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done)
					state_d = (sel_q == 2'd3) ? ST_BIN : ST_DIV_START;
			end
			ST_BIN: begin
				state_d = (32'(bin_calc) >= NUM_BINS) ? ST_OUT : ST_RD_A;
			end
			ST_RD_A: begin
				full_re = 1'b1;
				drop_re = 1'b1;
				state_d = ST_WR_A;
			end
			ST_WR_A: begin
				full_we = 1'b1;
				drop_we = 1'b1;
				state_d = (ba_eff != bb_eff) ? ST_RD_B : ST_OUT;
			end
			ST_RD_B: begin
				drop_re    = 1'b1;
				drop_raddr = ib_addr;
				state_d    = ST_WR_B;
			end
			ST_WR_B: begin
				drop_we    = 1'b1;
				drop_waddr = ib_addr;
				state_d    = ST_OUT;
			end
			ST_RD_Q: begin
				full_re    = 1'b1;
				drop_re    = 1'b1;
				drop_raddr = rq_addr;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			sel_q     <= '0;
			m_valid_q <= 1'b0;
			bc_q      <= 5'd2;
			le_q      <= -22'sd300000;
			fs_q      <= -22'sd20000;
			fe_q      <= 22'sd20000;
			he_q      <= 22'sd1050000;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + DROP_AW'(1);
			if (state_q == ST_CHECK)
				sel_q <= '0;
			else if (state_q == ST_DIV_WAIT && div_done)
				sel_q <= sel_q + 2'd1;
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_BLOCK_COUNT: bc_q <= cfg_data[4:0];
					REG_LOW_EDGE:    le_q <= cfg_data;
					REG_FINE_START:  fs_q <= cfg_data;
					REG_FINE_END:    fe_q <= cfg_data;
					REG_HIGH_EDGE:   he_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q   <= opcode_t'(s_tuser);
			x_q    <= s_tdata[23:0];
			pa_q   <= s_tdata[39:24];
			pb_q   <= s_tdata[55:40];
			ba_q   <= s_tdata[59:56];
			bb_q   <= s_tdata[63:60];
			kf_q   <= s_tdata[64];
			ks_q   <= s_tdata[65];
			dg_q   <= s_tdata[66];
			rb_q   <= s_tdata[74:67];
			rblk_q <= s_tdata[78:75];
		end
		if (state_q == ST_CHECK) begin
			bin8_q <= '0;
			prod_q <= SUM_W'(prod_raw);
			if (dg_q)
				status_q <= STAT_DIAG;
			else if (skip_missing)
				status_q <= STAT_MISSING;
			else if (out_of_edges)
				status_q <= STAT_RANGE;
			else
				status_q <= STAT_USED;
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			case (sel_q)
				2'd0: begin
					nf_q   <= div_quo;
					remf_q <= div_rem;
				end
				2'd1: begin
					nc_q   <= div_quo;
					remc_q <= div_rem;
				end
				2'd2: k_q <= div_quo;
				default: m_q <= div_quo;
			endcase
		end
		if (state_q == ST_BIN) begin
			bin_q <= bin_calc;
			if (32'(bin_calc) >= NUM_BINS)
				status_q <= STAT_RANGE;
			else
				bin8_q <= bin_calc[BINF_W-1:0];
		end
		if (out_load) begin
			m_status_q <= res_status;
			m_bin_q    <= res_bin;
			m_cnt_q    <= res_cnt;
			m_vs_q     <= res_vs;
			m_ps_q     <= res_ps;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {m_ps_q, m_vs_q, m_cnt_q, m_bin_q};

endmodule

[hdl/bpja_ram.sv]
module bpja_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[hdl/bpja_div.sv]
module bpja_div
	import bpja_pkg::*;
#(
	parameter int FINE_WIDTH   = FINE_WIDTH_DEF,
	parameter int COARSE_WIDTH = COARSE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              coarse,
	input  logic [DIVD_W-1:0] dividend,
	output logic              done,
	output logic [DIVD_W-1:0] quotient,
	output logic [DIVS_W-1:0] remainder
);

	// reciprocal m = floor(2^(N+l)/d) + 1 with l = ceil(log2 d) is exact for N-bit dividends
	localparam int MUL_W  = DIVD_W + 1;
	localparam int PROD_W = DIVD_W + MUL_W;
	localparam int QD_W   = DIVD_W + DIVS_W;
	localparam int F_SH   = DIVD_W + $clog2(FINE_WIDTH);
	localparam int C_SH   = DIVD_W + $clog2(COARSE_WIDTH);
	localparam longint F_RECIP = ((longint'(1) << F_SH) / FINE_WIDTH) + 1;
	localparam longint C_RECIP = ((longint'(1) << C_SH) / COARSE_WIDTH) + 1;

	logic              v_s1, v_s2;
	logic              coarse_s1, coarse_s2;
	logic [DIVD_W-1:0] dvd_s1, dvd_s2, quo_s2;
	logic [PROD_W-1:0] prod_s1;
	logic [MUL_W-1:0]  recip;
	logic [DIVD_W-1:0] quo_calc;
	logic [QD_W-1:0]   back_prod;
	logic [DIVD_W-1:0] rem_full;

	// stage 1 multiplies by the reciprocal, stage 2 shifts out the quotient
	assign recip     = coarse ? MUL_W'(C_RECIP) : MUL_W'(F_RECIP);
	assign quo_calc  = coarse_s1 ? DIVD_W'(prod_s1 >> C_SH) : DIVD_W'(prod_s1 >> F_SH);
	assign back_prod = quo_s2 * (coarse_s2 ? DIVS_W'(COARSE_WIDTH) : DIVS_W'(FINE_WIDTH));
	assign rem_full  = dvd_s2 - back_prod[DIVD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_s1    <= dividend;
			coarse_s1 <= coarse;
			prod_s1   <= dividend * recip;
		end
		if (v_s1) begin
			dvd_s2    <= dvd_s1;
			coarse_s2 <= coarse_s1;
			quo_s2    <= quo_calc;
		end
	end

	assign done      = v_s2;
	assign quotient  = quo_s2;
	assign remainder = rem_full[DIVS_W-1:0];

endmodule

[hdl/bpja_checker.sv]
module bpja_checker
	import bpja_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [1:0]            s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [2:0]            m_tuser
);

	// a held result word stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while previous item in work");

	// accumulate results carry no totals
	a_acc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_READ |-> m_tdata[OUT_DATA_W-1:BINF_W] == '0)
		else $error("accumulate result with nonzero totals");

	// skipped pairs report bin zero
	a_skip_bin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_DIAG || m_tuser == STAT_MISSING ||
		m_tuser == STAT_RANGE) |-> m_tdata[BINF_W-1:0] == '0)
		else $error("skipped pair with nonzero bin");

endmodule

bind binned_pair_jackknife_accumulator bpja_checker u_bpja_checker (.*);
